@@ hw/rtl/grp_pkg.sv @@
// shared types, constants and status codes for the guillotine rectangle placer
package grp_pkg;

    localparam int COORD_BITS = 15;
    localparam int FREE_SLOTS = 16;
    localparam int SLOT_BITS  = $clog2(FREE_SLOTS);
    localparam int CNT_BITS   = $clog2(FREE_SLOTS + 1);
    localparam int ABITS      = SLOT_BITS + 1;
    localparam int DEPTH      = 2 * FREE_SLOTS;
    localparam int PTR_BITS   = ABITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int BOX_BITS   = 4 * COORD_BITS;

    localparam logic [COORD_BITS-1:0] SIZE_RESET = COORD_BITS'(2048);

    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_CLEARED = 3'd1;
    localparam logic [2:0] ST_NOROOM  = 3'd2;
    localparam logic [2:0] ST_SKIPPED = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic LIST_ROW = 1'b0;
    localparam logic LIST_COL = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } t_box;

    typedef struct packed {
        logic                 found;
        logic [SLOT_BITS-1:0] idx;
        t_box                 box;
    } t_best;

    typedef struct packed {
        logic        action;
        logic        group_start;
        logic [14:0] rect_width;
        logic [14:0] rect_height;
        logic [23:0] rect_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [14:0] placed_width;
        logic [14:0] placed_height;
        logic        rotated;
        logic        opened_diagonal;
        logic [23:0] echo_id;
    } t_out;

endpackage

@@ hw/rtl/grp_ram.sv @@
// generic single write port ram with registered read
module grp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

@@ hw/rtl/grp_fit.sv @@
// best area fit unit: one free entry per cycle, area stage then compare stage
module grp_fit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_valid,
    input  grp_pkg::t_box                  i_box,
    input  logic [grp_pkg::SLOT_BITS-1:0]  i_idx,
    input  logic [grp_pkg::COORD_BITS-1:0] i_w,
    input  logic [grp_pkg::COORD_BITS-1:0] i_h,
    output logic                           o_busy,
    output grp_pkg::t_best                 o_best
);
    logic                          r_v;
    logic                          r_fit;
    logic [grp_pkg::AREA_BITS-1:0] r_area;
    grp_pkg::t_box                 r_box;
    logic [grp_pkg::SLOT_BITS-1:0] r_idx;
    grp_pkg::t_best                r_best;
    logic [grp_pkg::AREA_BITS-1:0] r_best_area;
    logic                          better;

    // area stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
        r_fit  <= (i_box.w >= i_w) && (i_box.h >= i_h);
        r_area <= grp_pkg::AREA_BITS'(i_box.w) * grp_pkg::AREA_BITS'(i_box.h);
        r_box  <= i_box;
        r_idx  <= i_idx;
    end

    // strict compare keeps the lower index on a full tie
    always_comb begin
        better = !r_best.found || (r_area < r_best_area) ||
                 ((r_area == r_best_area) && ((r_box.x < r_best.box.x) ||
                 ((r_box.x == r_best.box.x) && (r_box.y < r_best.box.y))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.found <= 1'b0;
        end else if (i_start) begin
            r_best.found <= 1'b0;
        end else if (r_v && r_fit && better) begin
            r_best.found <= 1'b1;
            r_best.idx   <= r_idx;
            r_best.box   <= r_box;
            r_best_area  <= r_area;
        end
    end

    assign o_busy = r_v;
    assign o_best = r_best;

    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && r_fit && better && !i_start) |=> (o_best.found && !$stable(o_best.box) ||
        o_best.found))
        else $error("best entry not recorded");
    a_busy_follows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> o_busy)
        else $error("area stage lost an entry");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_best.found)
        else $error("best not cleared at scan start");
endmodule

@@ hw/rtl/guillotine_rect_placer.sv @@
// top level: sequencer, anchor and snapshot state, free list and snapshot rams
// steps: a clear or skip goes straight to the result; a placement scans the row list and, if
//   nothing fits, the column list, then shifts the moved entries and appends, or opens a new
//   diagonal; a group start adds a save sweep first, undoing a group adds a restore sweep
// handshake: one word at a time, ready once the result register loads
// reset (synchronous, active low) empties the texture, clears the failed flag and sets
//   the texture side to 2048; ram contents are not cleared and need no sweep
module guillotine_rect_placer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  grp_pkg::t_in       i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output grp_pkg::t_out      o_out,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_data
);
    localparam int CB = grp_pkg::COORD_BITS;
    localparam int SB = grp_pkg::SLOT_BITS;
    localparam int AB = grp_pkg::ABITS;
    localparam int PB = grp_pkg::PTR_BITS;
    localparam int NB = grp_pkg::CNT_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SAVE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_APP0  = 4'd6;
    localparam logic [3:0] S_APP1  = 4'd7;
    localparam logic [3:0] S_OPEN  = 4'd8;
    localparam logic [3:0] S_LOAD  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]    r_state;
    logic [CB-1:0] r_w, r_h, r_size;

    // current texture state
    logic          r_anchor_valid;
    grp_pkg::t_box r_anchor;
    logic [NB-1:0] r_row_cnt, r_col_cnt;
    // snapshot scalars
    logic          r_snap_valid;
    grp_pkg::t_box r_snap_anchor;
    logic [NB-1:0] r_snap_row, r_snap_col;
    logic          r_group_failed;

    // scan context
    logic          r_list;
    logic [CB-1:0] r_sw, r_sh;
    logic [NB-1:0] r_scan_cnt;
    logic          r_fit_start;

    // sweep / scan read pipeline
    logic [PB-1:0] r_ptr;
    logic          r_rd_v;
    logic [AB-1:0] r_rd_addr;

    // pieces to append
    grp_pkg::t_box r_p0, r_p1;
    logic          r_p0_ok, r_p1_ok;
    logic [AB-1:0] r_a0, r_a1;

    grp_pkg::t_out r_res, r_out;
    logic          r_out_valid;
    grp_pkg::t_out acc_res;

    // ram ports
    logic                         cur_we, snap_we;
    logic [AB-1:0]                cur_waddr, cur_raddr, snap_raddr;
    logic [grp_pkg::BOX_BITS-1:0] cur_wdata, cur_q, snap_q;

    logic           issue, done_rd, in_acc;
    logic           fit_busy;
    grp_pkg::t_best best;

    // split of the chosen entry
    grp_pkg::t_box  sp0, sp1;
    logic [CB-1:0]  dw, dh;
    logic           sp0_ok, sp1_ok;
    logic [NB:0]    new_cnt;
    logic           over;

    // new diagonal
    logic [CB:0]   ax, ay;
    logic [CB+1:0] ex, ey, rem_x, rem_y, size_w;
    logic          open_fail;
    grp_pkg::t_box op0, op1;
    logic          op0_ok, op1_ok;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // result word as known at accept: id echoed, status for the quick cases
    always_comb begin
        acc_res         = '0;
        acc_res.echo_id = i_in.rect_id;
        if (i_in.action == grp_pkg::ACT_CLEAR) begin
            acc_res.status = grp_pkg::ST_CLEARED;
        end else if (!i_in.group_start && r_group_failed) begin
            acc_res.status = grp_pkg::ST_SKIPPED;
        end else begin
            acc_res.status = grp_pkg::ST_PLACED;
        end
    end

    // read issue: sweeps walk the whole ram, scans and removal walk one list
    always_comb begin
        case (r_state)
            S_SAVE, S_LOAD:  issue = (r_ptr < PB'(grp_pkg::DEPTH));
            S_SCAN, S_SHIFT: issue = (r_ptr < PB'(r_scan_cnt));
            default:         issue = 1'b0;
        endcase
    end

    assign done_rd    = !issue && !r_rd_v;
    assign cur_raddr  = (r_state == S_SAVE) ? r_ptr[AB-1:0] : {r_list, r_ptr[SB-1:0]};
    assign snap_raddr = r_ptr[AB-1:0];

    // snapshot ram written only by the save sweep
    assign snap_we = (r_state == S_SAVE) && r_rd_v;

    // free list ram write select
    always_comb begin
        cur_we    = 1'b0;
        cur_waddr = r_a0;
        cur_wdata = r_p0;
        case (r_state)
            S_LOAD: begin
                cur_we    = r_rd_v;
                cur_waddr = r_rd_addr;
                cur_wdata = snap_q;
            end
            S_SHIFT: begin
                // entry moves down by one slot
                cur_we    = r_rd_v;
                cur_waddr = {r_list, r_rd_addr[SB-1:0] - SB'(1)};
                cur_wdata = cur_q;
            end
            S_APP0: begin
                cur_we = r_p0_ok;
            end
            S_APP1: begin
                cur_we    = r_p1_ok;
                cur_waddr = r_a1;
                cur_wdata = r_p1;
            end
            default: begin
                cur_we = 1'b0;
            end
        endcase
    end

    grp_ram #(.WIDTH(grp_pkg::BOX_BITS), .DEPTH(grp_pkg::DEPTH)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_q)
    );

    grp_ram #(.WIDTH(grp_pkg::BOX_BITS), .DEPTH(grp_pkg::DEPTH)) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (snap_we),
        .i_waddr (r_rd_addr),
        .i_wdata (cur_q),
        .i_raddr (snap_raddr),
        .o_rdata (snap_q)
    );

    grp_fit u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_fit_start),
        .i_valid ((r_state == S_SCAN) && r_rd_v),
        .i_box   (grp_pkg::t_box'(cur_q)),
        .i_idx   (r_rd_addr[SB-1:0]),
        .i_w     (r_sw),
        .i_h     (r_sh),
        .o_busy  (fit_busy),
        .o_best  (best)
    );

    // guillotine split along the shorter leftover
    always_comb begin
        dw = best.box.w - r_sw;
        dh = best.box.h - r_sh;
        sp0.x = best.box.x + r_sw;
        sp0.y = best.box.y;
        sp0.w = dw;
        sp1.x = best.box.x;
        sp1.y = best.box.y + r_sh;
        sp1.h = dh;
        if (dw > dh) begin
            sp0.h = best.box.h;
            sp1.w = r_sw;
        end else begin
            sp0.h = r_sh;
            sp1.w = best.box.w;
        end
        sp0_ok  = (sp0.w != '0) && (sp0.h != '0);
        sp1_ok  = (sp1.w != '0) && (sp1.h != '0);
        new_cnt = (NB+1)'(r_scan_cnt) - (NB+1)'(1) + (NB+1)'(sp0_ok) + (NB+1)'(sp1_ok);
        over    = (new_cnt > (NB+1)'(grp_pkg::FREE_SLOTS));
    end

    // next diagonal opens at the far corner of the current anchor
    always_comb begin
        ax     = r_anchor_valid ? ((CB+1)'(r_anchor.x) + (CB+1)'(r_anchor.w)) : '0;
        ay     = r_anchor_valid ? ((CB+1)'(r_anchor.y) + (CB+1)'(r_anchor.h)) : '0;
        ex     = (CB+2)'(ax) + (CB+2)'(r_w);
        ey     = (CB+2)'(ay) + (CB+2)'(r_h);
        size_w = (CB+2)'(r_size);
        open_fail = (ex > size_w) || (ey > size_w);
        rem_x  = size_w - ex;
        rem_y  = size_w - ey;
        op0.x  = CB'(ex);
        op0.y  = CB'(ay);
        op0.w  = CB'(rem_x);
        op0.h  = r_h;
        op1.x  = CB'(ax);
        op1.y  = CB'(ey);
        op1.w  = r_w;
        op1.h  = CB'(rem_y);
        op0_ok = (rem_x != '0) && (r_h != '0);
        op1_ok = (r_w != '0) && (rem_y != '0);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= grp_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= CB'(i_cfg_data);
        end
    end

    // read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= issue;
        end
        r_rd_addr <= (r_state == S_LOAD) ? snap_raddr : cur_raddr;
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_anchor_valid <= 1'b0;
            r_anchor       <= '0;
            r_row_cnt      <= '0;
            r_col_cnt      <= '0;
            r_snap_valid   <= 1'b0;
            r_snap_anchor  <= '0;
            r_snap_row     <= '0;
            r_snap_col     <= '0;
            r_group_failed <= 1'b0;
            r_fit_start    <= 1'b0;
            r_out_valid    <= 1'b0;
            r_ptr          <= '0;
        end else begin
            // fit unit restarts on entry to each list scan
            r_fit_start <= ((r_state == S_START) && r_anchor_valid) ||
                           ((r_state == S_EVAL) && !best.found &&
                            (r_list == grp_pkg::LIST_ROW));
            if (issue) begin
                r_ptr <= r_ptr + PB'(1);
            end
            // a word taken while the next one loads stays valid
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_w   <= CB'(i_in.rect_width);
                        r_h   <= CB'(i_in.rect_height);
                        r_res <= acc_res;
                        r_ptr <= '0;
                        if (i_in.action == grp_pkg::ACT_CLEAR) begin
                            r_anchor_valid <= 1'b0;
                            r_anchor       <= '0;
                            r_row_cnt      <= '0;
                            r_col_cnt      <= '0;
                            r_snap_valid   <= 1'b0;
                            r_snap_anchor  <= '0;
                            r_snap_row     <= '0;
                            r_snap_col     <= '0;
                            r_group_failed <= 1'b0;
                            r_state        <= S_DONE;
                        end else if (i_in.group_start) begin
                            r_snap_valid   <= r_anchor_valid;
                            r_snap_anchor  <= r_anchor;
                            r_snap_row     <= r_row_cnt;
                            r_snap_col     <= r_col_cnt;
                            r_group_failed <= 1'b0;
                            r_state        <= S_SAVE;
                        end else if (r_group_failed) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_START;
                        end
                    end
                end
                S_SAVE: begin
                    if (done_rd) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    if (r_anchor_valid) begin
                        r_list      <= grp_pkg::LIST_ROW;
                        r_sw        <= r_w;
                        r_sh        <= r_h;
                        r_scan_cnt  <= r_row_cnt;
                        r_ptr       <= '0;
                        r_state     <= S_SCAN;
                    end else begin
                        r_state <= S_OPEN;
                    end
                end
                S_SCAN: begin
                    if (done_rd && !fit_busy && !r_fit_start) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!best.found) begin
                        if (r_list == grp_pkg::LIST_ROW) begin
                            // column list is tried with the sides swapped
                            r_list      <= grp_pkg::LIST_COL;
                            r_sw        <= r_h;
                            r_sh        <= r_w;
                            r_scan_cnt  <= r_col_cnt;
                            r_ptr       <= '0;
                            r_state     <= S_SCAN;
                        end else begin
                            r_state <= S_OPEN;
                        end
                    end else if (over) begin
                        r_anchor_valid <= r_snap_valid;
                        r_anchor       <= r_snap_anchor;
                        r_row_cnt      <= r_snap_row;
                        r_col_cnt      <= r_snap_col;
                        r_group_failed <= 1'b1;
                        r_res.status   <= grp_pkg::ST_FULL;
                        r_ptr          <= '0;
                        r_state        <= S_LOAD;
                    end else begin
                        r_p0    <= sp0;
                        r_p1    <= sp1;
                        r_p0_ok <= sp0_ok;
                        r_p1_ok <= sp1_ok;
                        r_a0    <= {r_list, SB'(r_scan_cnt - NB'(1))};
                        r_a1    <= {r_list, SB'(r_scan_cnt - NB'(1) + NB'(sp0_ok))};
                        if (r_list == grp_pkg::LIST_ROW) begin
                            r_row_cnt <= NB'(new_cnt);
                        end else begin
                            r_col_cnt <= NB'(new_cnt);
                        end
                        r_res.status        <= grp_pkg::ST_PLACED;
                        r_res.pos_x         <= 14'(best.box.x);
                        r_res.pos_y         <= 14'(best.box.y);
                        r_res.placed_width  <= 15'(r_sw);
                        r_res.placed_height <= 15'(r_sh);
                        r_res.rotated       <= r_list;
                        r_ptr               <= PB'(best.idx) + PB'(1);
                        r_state             <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (done_rd) begin
                        r_state <= S_APP0;
                    end
                end
                S_APP0: begin
                    r_state <= S_APP1;
                end
                S_APP1: begin
                    r_state <= S_DONE;
                end
                S_OPEN: begin
                    if (open_fail) begin
                        r_anchor_valid <= r_snap_valid;
                        r_anchor       <= r_snap_anchor;
                        r_row_cnt      <= r_snap_row;
                        r_col_cnt      <= r_snap_col;
                        r_group_failed <= 1'b1;
                        r_res.status   <= grp_pkg::ST_NOROOM;
                        r_ptr          <= '0;
                        r_state        <= S_LOAD;
                    end else begin
                        r_anchor_valid <= 1'b1;
                        r_anchor.x     <= CB'(ax);
                        r_anchor.y     <= CB'(ay);
                        r_anchor.w     <= r_w;
                        r_anchor.h     <= r_h;
                        r_row_cnt      <= NB'(op0_ok);
                        r_col_cnt      <= NB'(op1_ok);
                        r_p0           <= op0;
                        r_p1           <= op1;
                        r_p0_ok        <= op0_ok;
                        r_p1_ok        <= op1_ok;
                        r_a0           <= {grp_pkg::LIST_ROW, SB'(0)};
                        r_a1           <= {grp_pkg::LIST_COL, SB'(0)};
                        r_res.status          <= grp_pkg::ST_PLACED;
                        r_res.pos_x           <= 14'(ax);
                        r_res.pos_y           <= 14'(ay);
                        r_res.placed_width    <= 15'(r_w);
                        r_res.placed_height   <= 15'(r_h);
                        r_res.opened_diagonal <= 1'b1;
                        r_state               <= S_APP0;
                    end
                end
                S_LOAD: begin
                    if (done_rd) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // output register frees up when the previous word is taken
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row_cnt <= NB'(grp_pkg::FREE_SLOTS)) && (r_col_cnt <= NB'(grp_pkg::FREE_SLOTS)))
        else $error("free list count beyond capacity");
    a_no_anchor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_anchor_valid |-> (r_row_cnt == '0) && (r_col_cnt == '0))
        else $error("free entries without an anchor");
    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != grp_pkg::ST_PLACED)) |->
        (o_out.placed_width == '0) && (o_out.rotated == 1'b0) &&
        (o_out.opened_diagonal == 1'b0))
        else $error("placement fields set on a non-placed word");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("accepted a word while busy");
    a_eval_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && best.found) |-> (best.box.w >= r_sw) && (best.box.h >= r_sh))
        else $error("chosen free entry too small");
endmodule
